/* hw/rtl/sae_pkg.sv */
`timescale 1ns / 1ps
package sae_pkg;
  localparam int SERVO_COUNT_DEF = 4;
  localparam int OUT_SLOTS = 4;

  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_SET_ALL = 3'd1;
  localparam logic [2:0] MODE_SET_ONE = 3'd2;
  localparam logic [2:0] MODE_MOVE_TO = 3'd3;
  localparam logic [2:0] MODE_MOVE_BY = 3'd4;
  localparam logic [2:0] MODE_ZERO = 3'd5;
  localparam logic [2:0] MODE_STOP = 3'd6;

  localparam logic [1:0] STATUS_NONE = 2'd0;
  localparam logic [1:0] STATUS_DONE = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  localparam logic [2:0] REG_LOWER = 3'd0;
  localparam logic [2:0] REG_UPPER = 3'd1;
  localparam logic [2:0] REG_MOVE_SPEED = 3'd2;
  localparam logic [2:0] REG_RATE_GAIN = 3'd3;
  localparam logic [2:0] REG_DUR_GAIN = 3'd4;

  localparam logic signed [31:0] LOWER_RST = 32'sh8000_0000;
  localparam logic signed [31:0] UPPER_RST = 32'sh7FFF_FFFF;
  localparam logic [6:0] MOVE_SPEED_RST = 7'd25;
  localparam logic [19:0] RATE_GAIN_RST = 20'd47920;
  localparam logic [19:0] DUR_GAIN_RST = 20'd10756;

  // shared multiplier: 32 x 24 unsigned
  typedef struct packed {
    logic [31:0] a;
    logic [23:0] b;
  } mul_req_t;

  function automatic logic [10:0] pulse_of(input logic signed [7:0] s);
    logic signed [12:0] p;
    p = 13'sd1500 + 13'(s) * 13'sd5;
    return p[10:0];
  endfunction
endpackage

/* hw/rtl/sae_mul.sv */
`timescale 1ns / 1ps
module sae_mul
  import sae_pkg::*;
(
  input  logic        clk,
  input  mul_req_t    req,
  output logic [55:0] prod
);
  always_ff @(posedge clk) begin
    prod <= {24'd0, req.a} * {32'd0, req.b};
  end
endmodule

/* hw/rtl/servo_angle_estimator_failsafe.sv */
`timescale 1ns / 1ps
// servo angle estimator with limit failsafe. one word in gives one word out.
// every word is worked by a small sequencer around a single registered
// 32x24 multiplier: each servo's tick step takes two products (elapsed*|speed|,
// then times the rate gain) plus an update step; accepted move commands add
// the duration product and the speed update. zero, stop and unused modes
// skip the tick steps. in_ready is low while a word is worked and while a
// result waits in the output register. configuration is an apb port,
// register i at byte address 4*i, to be written by the user only while idle;
// the block itself does not enforce this.
module servo_angle_estimator_failsafe
  import sae_pkg::*;
#(
  parameter int SERVO_COUNT = SERVO_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode,
  input  logic [1:0]         servo_select,
  input  logic signed [7:0]  speed_request,
  input  logic signed [31:0] angle_value,
  input  logic [15:0]        elapsed_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [10:0]        pulse_a,
  output logic [10:0]        pulse_b,
  output logic [10:0]        pulse_c,
  output logic [10:0]        pulse_d,
  output logic signed [31:0] angle_a,
  output logic signed [31:0] angle_b,
  output logic signed [31:0] angle_c,
  output logic signed [31:0] angle_d,
  output logic               move_active,
  output logic [3:0]         failsafe_mask,
  output logic [3:0]         blocked_mask,
  output logic [1:0]         move_status
);
  localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL1  = 10'b0000000010,
    S_MUL2  = 10'b0000000100,
    S_UPD   = 10'b0000001000,
    S_CMD   = 10'b0000010000,
    S_DMUL  = 10'b0000100000,
    S_DWAIT = 10'b0001000000,
    S_SETSP = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_HOLD  = 10'b1000000000
  } state_t;

  // configuration
  logic signed [31:0] lower_lim, upper_lim;
  logic [6:0]  move_speed;
  logic [19:0] rate_gain, dur_gain;
  logic [2:0]  reg_idx;
  assign reg_idx = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_lim <= LOWER_RST;
      upper_lim <= UPPER_RST;
      move_speed <= MOVE_SPEED_RST;
      rate_gain <= RATE_GAIN_RST;
      dur_gain <= DUR_GAIN_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_LOWER:      lower_lim <= pwdata;
        REG_UPPER:      upper_lim <= pwdata;
        REG_MOVE_SPEED: move_speed <= pwdata[6:0];
        REG_RATE_GAIN:  rate_gain <= pwdata[19:0];
        REG_DUR_GAIN:   dur_gain <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LOWER:      prdata = lower_lim;
      REG_UPPER:      prdata = upper_lim;
      REG_MOVE_SPEED: prdata = {25'd0, move_speed};
      REG_RATE_GAIN:  prdata = {12'd0, rate_gain};
      REG_DUR_GAIN:   prdata = {12'd0, dur_gain};
      default:        prdata = 32'd0;
    endcase
  end

  // state
  logic signed [7:0]  speed [SERVO_COUNT];
  logic signed [31:0] angle [SERVO_COUNT];
  logic               running;
  logic signed [31:0] target;
  logic [39:0]        remain;

  state_t state;
  logic [IW-1:0] idx;
  logic [2:0]  c_mode;
  logic [1:0]  c_sel;
  logic signed [7:0]  c_req;
  logic signed [31:0] c_av;
  logic [15:0] c_el;
  logic [SERVO_COUNT-1:0] fs, bl;
  logic [1:0]  status;
  logic [55:0] prod;
  mul_req_t    mreq;
  logic signed [7:0] move_sp;
  logic [31:0] mag;

  sae_mul u_mul (.clk(clk), .req(mreq), .prod(prod));

  logic signed [7:0] spd_i;
  logic [7:0] spd_abs;
  assign spd_i = speed[idx];
  assign spd_abs = spd_i[7] ? 8'(-spd_i) : 8'(spd_i);

  always_comb begin
    mreq.a = 32'd0;
    mreq.b = 24'd0;
    unique case (state)
      S_MUL1: begin mreq.a = {16'd0, c_el}; mreq.b = {16'd0, spd_abs}; end
      S_MUL2: begin mreq.a = prod[31:0]; mreq.b = {4'd0, rate_gain}; end
      S_DMUL: begin mreq.a = mag; mreq.b = {4'd0, dur_gain}; end
      default: ;
    endcase
  end

  // tick update for servo idx; prod holds the magnitude product
  logic [31:0] dmag;
  logic signed [33:0] sum;
  assign dmag = spd_i[7] ? 32'(prod[55:24] + 32'(|prod[23:0])) : prod[55:24];
  assign sum = spd_i[7] ? 34'(angle[idx]) - 34'(dmag) : 34'(angle[idx]) + 34'(dmag);

  // command target and difference to servo 0
  logic signed [33:0] raw_t, diff;
  logic signed [31:0] tgt;
  always_comb begin
    raw_t = (c_mode == MODE_MOVE_BY) ? 34'(angle[0]) + 34'(c_av) : 34'(c_av);
    if (raw_t < 34'(lower_lim)) tgt = lower_lim;
    else if (raw_t > 34'(upper_lim)) tgt = upper_lim;
    else tgt = raw_t[31:0];
    diff = 34'(tgt) - 34'(angle[0]);
  end

  // speed with limit blocking
  function automatic logic signed [7:0] blk(input logic signed [31:0] a,
      input logic signed [7:0] s, input logic signed [31:0] lo,
      input logic signed [31:0] hi);
    logic signed [7:0] r;
    r = s;
    if (a >= hi && s > 0) r = 8'sd0;
    if (a <= lo && s < 0) r = 8'sd0;
    return r;
  endfunction

  logic signed [7:0] req_c;
  assign req_c = (c_req > 8'sd100) ? 8'sd100 : (c_req < -8'sd100) ? -8'sd100 : c_req;

  logic [39:0] dur;
  assign dur = (prod[55:48] != 8'd0) ? 40'hFF_FFFF_FFFF : prod[47:8];

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      running <= 1'b0;
      target <= 32'sd0;
      remain <= 40'd0;
      idx <= '0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        speed[i] <= 8'sd0;
        angle[i] <= 32'sd0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) begin
          c_mode <= mode; c_sel <= servo_select; c_req <= speed_request;
          c_av <= angle_value; c_el <= elapsed_us;
          fs <= '0; bl <= '0; status <= STATUS_NONE; idx <= '0;
          state <= (mode <= MODE_MOVE_BY) ? S_MUL1 : S_CMD;
        end
        S_MUL1: state <= S_MUL2;
        S_MUL2: state <= S_UPD;
        S_UPD: begin
          if (spd_i != 8'sd0) begin
            if (sum >= 34'(upper_lim)) begin
              angle[idx] <= upper_lim; speed[idx] <= 8'sd0; fs[idx] <= 1'b1;
            end else if (sum <= 34'(lower_lim)) begin
              angle[idx] <= lower_lim; speed[idx] <= 8'sd0; fs[idx] <= 1'b1;
            end else begin
              angle[idx] <= sum[31:0];
            end
          end
          if (32'(idx) == SERVO_COUNT - 1) begin
            remain <= (remain > 40'(c_el)) ? remain - 40'(c_el) : 40'd0;
            idx <= '0;
            state <= S_CMD;
          end else begin
            idx <= idx + 1'b1;
            state <= S_MUL1;
          end
        end
        S_CMD: begin
          state <= S_OUT;
          case (c_mode)
            MODE_TICK: if (running && remain == 40'd0) begin
              for (int i = 0; i < SERVO_COUNT; i++) begin
                speed[i] <= 8'sd0; angle[i] <= target;
              end
              running <= 1'b0; status <= STATUS_DONE;
            end
            MODE_SET_ALL: begin
              running <= 1'b0;
              for (int i = 0; i < SERVO_COUNT; i++) begin
                speed[i] <= blk(angle[i], req_c, lower_lim, upper_lim);
                bl[i] <= blk(angle[i], req_c, lower_lim, upper_lim) != req_c;
              end
            end
            MODE_SET_ONE: begin
              running <= 1'b0;
              for (int i = 0; i < SERVO_COUNT; i++) begin
                if (32'(c_sel) == i) begin
                  speed[i] <= blk(angle[i], req_c, lower_lim, upper_lim);
                  bl[i] <= blk(angle[i], req_c, lower_lim, upper_lim) != req_c;
                end
              end
            end
            MODE_MOVE_TO, MODE_MOVE_BY: begin
              if (diff > -34'sd128 && diff < 34'sd128) begin
                status <= STATUS_REJECT;
              end else begin
                target <= tgt;
                mag <= diff[33] ? 32'(-diff) : diff[31:0];
                move_sp <= (move_speed > 7'd100) ? 8'sd100 : 8'(move_speed);
                state <= S_DMUL;
              end
            end
            MODE_ZERO: begin
              running <= 1'b0;
              for (int i = 0; i < SERVO_COUNT; i++) begin
                speed[i] <= 8'sd0; angle[i] <= 32'sd0;
              end
            end
            MODE_STOP: begin
              running <= 1'b0;
              for (int i = 0; i < SERVO_COUNT; i++) speed[i] <= 8'sd0;
            end
            default: ;
          endcase
        end
        S_DMUL: state <= S_DWAIT;
        S_DWAIT: begin
          remain <= dur;
          running <= 1'b1;
          if (diff[33]) move_sp <= -move_sp;
          state <= S_SETSP;
        end
        S_SETSP: begin
          for (int i = 0; i < SERVO_COUNT; i++) begin
            speed[i] <= blk(angle[i], move_sp, lower_lim, upper_lim);
            bl[i] <= blk(angle[i], move_sp, lower_lim, upper_lim) != move_sp;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_HOLD;
        end
        S_HOLD: if (out_ready) begin
          out_valid <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded once per word
  logic [10:0] pul [OUT_SLOTS];
  logic signed [31:0] ang [OUT_SLOTS];
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      for (int i = 0; i < OUT_SLOTS; i++) begin
        if (i < SERVO_COUNT) begin
          pul[i] <= pulse_of(speed[i]);
          ang[i] <= angle[i];
        end else begin
          pul[i] <= 11'd1500;
          ang[i] <= 32'sd0;
        end
      end
      move_active <= running;
      failsafe_mask <= 4'(fs);
      blocked_mask <= 4'(bl);
      move_status <= status;
    end
  end

  assign pulse_a = pul[0];
  assign pulse_b = pul[1];
  assign pulse_c = pul[2];
  assign pulse_d = pul[3];
  assign angle_a = ang[0];
  assign angle_b = ang[1];
  assign angle_c = ang[2];
  assign angle_d = ang[3];
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import sae_pkg::*;

  // one input word and one output word
  typedef struct {
    logic [2:0]         mode;
    logic [1:0]         sel;
    logic signed [7:0]  spd;
    logic signed [31:0] ang;
    logic [15:0]        us;
  } cmd_t;

  typedef struct {
    logic [10:0] pulse [4];
    logic [31:0] angle [4];
    logic        active;
    logic [3:0]  fail;
    logic [3:0]  blocked;
    logic [1:0]  status;
  } report_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] mode = 0;
  logic [1:0] servo_select = 0;
  logic signed [7:0] speed_request = 0;
  logic signed [31:0] angle_value = 0;
  logic [15:0] elapsed_us = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [10:0] pulse_a, pulse_b, pulse_c, pulse_d;
  logic signed [31:0] angle_a, angle_b, angle_c, angle_d;
  logic move_active;
  logic [3:0] failsafe_mask, blocked_mask;
  logic [1:0] move_status;

  servo_angle_estimator_failsafe uut (.*);

  initial forever #5 clk = ~clk;

  // predictor copy of registers and state
  logic signed [63:0] lim_lo, lim_hi;
  logic [6:0] mv_speed;
  logic [19:0] rate_gain, dur_gain;
  logic signed [7:0] spd_st [4];
  logic signed [63:0] ang_st [4];
  logic mv_run;
  logic signed [63:0] mv_target;
  logic [39:0] mv_left;

  cmd_t pending_cmds[$];
  report_t expected_reports[$];
  int errors = 0;
  int send_idle = 6, recv_idle = 45;
  bit recv_hold = 0, send_hold = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  function automatic void set_speed_one(int i, logic signed [7:0] s, ref logic [3:0] blk);
    if (ang_st[i] >= lim_hi && s > 0) begin
      s = 0;
      blk[i] = 1;
    end
    if (ang_st[i] <= lim_lo && s < 0) begin
      s = 0;
      blk[i] = 1;
    end
    spd_st[i] = s;
  endfunction

  function automatic logic [1:0] begin_move(logic signed [63:0] tgt, ref logic [3:0] blk);
    logic signed [63:0] diff;
    logic [63:0] mag, dur;
    logic signed [7:0] sp;
    diff = tgt - ang_st[0];
    sp = (mv_speed > 100) ? 8'sd100 : 8'(mv_speed);
    if (diff > -128 && diff < 128) return STATUS_REJECT;
    if (diff < 0) begin
      sp = -sp;
      mag = -diff;
    end else mag = diff;
    dur = (mag * dur_gain) >> 8;
    if (dur > 64'hFF_FFFF_FFFF) dur = 64'hFF_FFFF_FFFF;
    mv_run = 1;
    mv_target = tgt;
    mv_left = dur[39:0];
    for (int i = 0; i < 4; i++) set_speed_one(i, sp, blk);
    return STATUS_NONE;
  endfunction

  function automatic logic signed [63:0] clamp_lim(logic signed [63:0] v);
    if (v < lim_lo) return lim_lo;
    if (v > lim_hi) return lim_hi;
    return v;
  endfunction

  // compute the expected report for one word and advance state
  function automatic report_t predict_report(cmd_t c);
    report_t r;
    logic [3:0] fs, blk;
    logic [1:0] st;
    logic signed [7:0] req;
    logic signed [63:0] p, d;
    fs = 0;
    blk = 0;
    st = STATUS_NONE;
    req = (c.spd > 100) ? 8'sd100 : (c.spd < -100) ? -8'sd100 : c.spd;
    if (c.mode <= MODE_MOVE_BY) begin
      for (int i = 0; i < 4; i++) begin
        if (spd_st[i] != 0) begin
          p = $signed({48'd0, c.us}) * 64'(spd_st[i]) * $signed({44'd0, rate_gain});
          d = p >>> 24;  // floor
          ang_st[i] += d;
          if (ang_st[i] >= lim_hi) begin
            ang_st[i] = lim_hi;
            spd_st[i] = 0;
            fs[i] = 1;
          end else if (ang_st[i] <= lim_lo) begin
            ang_st[i] = lim_lo;
            spd_st[i] = 0;
            fs[i] = 1;
          end
        end
      end
      mv_left = (mv_left > c.us) ? mv_left - c.us : 40'd0;
    end
    case (c.mode)
      MODE_TICK: if (mv_run && mv_left == 0) begin
        for (int i = 0; i < 4; i++) begin
          spd_st[i] = 0;
          ang_st[i] = mv_target;
        end
        mv_run = 0;
        st = STATUS_DONE;
      end
      MODE_SET_ALL: begin
        mv_run = 0;
        for (int i = 0; i < 4; i++) set_speed_one(i, req, blk);
      end
      MODE_SET_ONE: begin
        mv_run = 0;
        set_speed_one(c.sel, req, blk);
      end
      MODE_MOVE_TO: st = begin_move(clamp_lim(64'(c.ang)), blk);
      MODE_MOVE_BY: st = begin_move(clamp_lim(ang_st[0] + 64'(c.ang)), blk);
      MODE_ZERO: begin
        mv_run = 0;
        for (int i = 0; i < 4; i++) begin
          spd_st[i] = 0;
          ang_st[i] = 0;
        end
      end
      MODE_STOP: begin
        mv_run = 0;
        for (int i = 0; i < 4; i++) spd_st[i] = 0;
      end
      default: ;
    endcase
    for (int i = 0; i < 4; i++) begin
      r.pulse[i] = 11'(1500 + 5 * int'(spd_st[i]));
      r.angle[i] = ang_st[i][31:0];
    end
    r.active = mv_run;
    r.fail = fs;
    r.blocked = blk;
    r.status = st;
    return r;
  endfunction

  // driver: feeds words from the pending queue
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_reports.push_back(predict_report(pending_cmds.pop_front()));
      end
      if ((!in_valid || in_ready) ) begin
        if (in_valid && in_ready || !in_valid) begin
          // offer next word unless idling, holding or queue is empty
          if (pending_cmds.size() > 0 && !send_hold &&
              $urandom_range(99) >= send_idle) begin
            cmd_t c;
            c = pending_cmds[0];
            in_valid <= 1;
            mode <= c.mode;
            servo_select <= c.sel;
            speed_request <= c.spd;
            angle_value <= c.ang;
            elapsed_us <= c.us;
          end else in_valid <= 0;
        end
      end
    end
  end

  // receiver side: random stalls plus an optional long hold
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) out_ready <= 0;
    else begin
      if (recv_hold) hold_cycles <= hold_cycles + 1;
      out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: compare each output word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected output word", $time);
        errors++;
      end else begin
        report_t e, a;
        e = expected_reports.pop_front();
        a.pulse = '{pulse_a, pulse_b, pulse_c, pulse_d};
        a.angle = '{angle_a, angle_b, angle_c, angle_d};
        a.active = move_active;
        a.fail = failsafe_mask;
        a.blocked = blocked_mask;
        a.status = move_status;
        for (int i = 0; i < 4; i++) begin
          if (a.pulse[i] !== e.pulse[i]) begin
            $display("%0t: pulse[%0d] expected %0d actual %0d", $time, i, e.pulse[i],
                     a.pulse[i]);
            errors++;
          end
          if (a.angle[i] !== e.angle[i]) begin
            $display("%0t: angle[%0d] expected %0d actual %0d", $time, i,
                     $signed(e.angle[i]), $signed(a.angle[i]));
            errors++;
          end
        end
        if (a.active !== e.active) begin
          $display("%0t: move_active expected %0d actual %0d", $time, e.active, a.active);
          errors++;
        end
        if (a.fail !== e.fail) begin
          $display("%0t: failsafe_mask expected %h actual %h", $time, e.fail, a.fail);
          errors++;
        end
        if (a.blocked !== e.blocked) begin
          $display("%0t: blocked_mask expected %h actual %h", $time, e.blocked, a.blocked);
          errors++;
        end
        if (a.status !== e.status) begin
          $display("%0t: move_status expected %0d actual %0d", $time, e.status, a.status);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > 3_000_000) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      REG_LOWER: lim_lo = $signed(val);
      REG_UPPER: lim_hi = $signed(val);
      REG_MOVE_SPEED: mv_speed = val[6:0];
      REG_RATE_GAIN: rate_gain = val[19:0];
      default: dur_gain = val[19:0];
    endcase
  endtask

  // wait for the pipeline to empty
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic cmd_t make_cmd(logic [2:0] m, logic [1:0] s, logic signed [7:0] sp,
                                    logic signed [31:0] a, logic [15:0] u);
    cmd_t c;
    c.mode = m;
    c.sel = s;
    c.spd = sp;
    c.ang = a;
    c.us = u;
    return c;
  endfunction

  // mostly ticks of modest length, with commands and full-range noise
  function automatic cmd_t random_cmd();
    cmd_t c;
    int k;
    k = $urandom_range(99);
    c.sel = 2'($urandom);
    c.spd = (k % 7 == 0) ? 8'($urandom) : 8'($urandom_range(200)) - 8'sd100;
    c.ang = (k % 5 == 0) ? 32'($urandom) : $signed(32'($urandom_range(40000))) - 20000;
    c.us = (k % 9 == 0) ? 16'($urandom) : 16'($urandom_range(3000));
    if (k < 55) c.mode = MODE_TICK;
    else if (k < 65) c.mode = MODE_SET_ALL;
    else if (k < 75) c.mode = MODE_SET_ONE;
    else if (k < 83) c.mode = MODE_MOVE_TO;
    else if (k < 91) c.mode = MODE_MOVE_BY;
    else if (k < 94) c.mode = MODE_ZERO;
    else if (k < 97) c.mode = MODE_STOP;
    else c.mode = 3'($urandom_range(7));
    return c;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      pending_cmds.push_back(random_cmd());
      if (pending_cmds.size() > 20) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    lim_lo = LOWER_RST;
    lim_hi = UPPER_RST;
    mv_speed = MOVE_SPEED_RST;
    rate_gain = RATE_GAIN_RST;
    dur_gain = DUR_GAIN_RST;
    for (int i = 0; i < 4; i++) begin
      spd_st[i] = 0;
      ang_st[i] = 0;
    end
    mv_run = 0;
    mv_target = 0;
    mv_left = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // directed: extremes, every mode, blocking, rejection, completion
    pending_cmds.push_back(make_cmd(MODE_SET_ALL, 0, 8'sd127, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(MODE_SET_ONE, 3, -8'sd128, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 16'd1000));
    pending_cmds.push_back(make_cmd(MODE_MOVE_BY, 0, 0, 32'sd127, 0));
    pending_cmds.push_back(make_cmd(MODE_MOVE_BY, 0, 0, -32'sd127, 0));
    pending_cmds.push_back(make_cmd(MODE_MOVE_TO, 0, 0, 32'sd2560, 0));
    for (int i = 0; i < 4; i++)
      pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 16'd40000));
    pending_cmds.push_back(make_cmd(MODE_MOVE_TO, 0, 0, 32'sh8000_0000, 0));
    pending_cmds.push_back(make_cmd(MODE_MOVE_TO, 0, 0, 32'sh7FFF_FFFF, 0));
    pending_cmds.push_back(make_cmd(MODE_ZERO, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(3'd7, 2, 8'sd5, 0, 16'd5));
    pending_cmds.push_back(make_cmd(MODE_STOP, 0, 0, 0, 0));
    drain();

    // tight limits and fast gains
    reg_write(REG_LOWER, -32'sd2000);
    reg_write(REG_UPPER, 32'sd2000);
    reg_write(REG_MOVE_SPEED, 7'd127);
    reg_write(REG_RATE_GAIN, 20'hFFFFF);
    reg_write(REG_DUR_GAIN, 20'd0);
    pending_cmds.push_back(make_cmd(MODE_SET_ALL, 0, 8'sd100, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 16'd500));
    pending_cmds.push_back(make_cmd(MODE_SET_ALL, 0, 8'sd50, 0, 0));
    pending_cmds.push_back(make_cmd(MODE_SET_ONE, 1, -8'sd100, 0, 16'd2000));
    pending_cmds.push_back(make_cmd(MODE_MOVE_TO, 0, 0, -32'sd5000, 0));
    pending_cmds.push_back(make_cmd(MODE_TICK, 0, 0, 0, 16'd1));
    drain();

    random_phase(350);
    reg_write(REG_LOWER, 32'sd1000);
    reg_write(REG_UPPER, -32'sd1000);
    random_phase(100);

    // sender idles rarely, receiver often
    reg_write(REG_LOWER, -32'sd60000);
    reg_write(REG_UPPER, 32'sd60000);
    reg_write(REG_MOVE_SPEED, 7'd1);
    reg_write(REG_RATE_GAIN, RATE_GAIN_RST);
    reg_write(REG_DUR_GAIN, DUR_GAIN_RST);
    random_phase(350);

    // other way round, with a long receiver hold
    send_idle = 45;
    recv_idle = 6;
    reg_write(REG_MOVE_SPEED, 7'd100);
    reg_write(REG_RATE_GAIN, 20'd300000);
    recv_hold = 1;
    for (int i = 0; i < 30; i++) pending_cmds.push_back(random_cmd());
    wait (hold_cycles >= 400);
    recv_hold = 0;
    drain();
    random_phase(350);

    // no idling, reset limits and maximum duration gain
    send_idle = 0;
    recv_idle = 0;
    reg_write(REG_LOWER, LOWER_RST);
    reg_write(REG_UPPER, UPPER_RST);
    reg_write(REG_DUR_GAIN, 20'hFFFFF);
    random_phase(350);

    if (errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

/* filelist.f */
hw/rtl/sae_pkg.sv
hw/rtl/sae_mul.sv
hw/rtl/servo_angle_estimator_failsafe.sv
tb/sv/testbench.sv
